>>> rtl/core/font_rom_glyph_fetch_defines.svh
// ----------------------------------------------------------------------------
// font_rom_glyph_fetch_defines
// assertion macros shared by the glyph fetch rtl
// ----------------------------------------------------------------------------
`ifndef FONT_ROM_GLYPH_FETCH_DEFINES_SVH
`define FONT_ROM_GLYPH_FETCH_DEFINES_SVH

`ifndef ASSERT_OFF
// check a property on a clock, gated by an active-low reset
`define FRGF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on a clock with no reset gating
`define FRGF_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRGF_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRGF_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/frgf_pkg.sv
// ----------------------------------------------------------------------------
// frgf_pkg
// types and constants for the font rom glyph fetch block
// ----------------------------------------------------------------------------
package frgf_pkg;

    // glyph sizes in bytes
    localparam int ASCII_GLYPH_BYTES_DEF = 16;
    localparam int WIDE_GLYPH_BYTES_DEF  = 32;

    // input opcodes
    localparam logic [1:0] OP_START_ASCII = 2'd0;
    localparam logic [1:0] OP_START_WIDE  = 2'd1;
    localparam logic [1:0] OP_TICK        = 2'd2;

    // serial header
    localparam logic [7:0] CMD_FAST_READ   = 8'h0B;
    localparam logic [7:0] DUMMY_BYTE      = 8'h55;
    localparam logic [5:0] HEADER_BITS     = 6'd40;

    // address map
    localparam logic [23:0] ASCII_BASE     = 24'd255968;
    localparam logic [23:0] WIDE_OFF_A     = 24'd0;
    localparam logic [23:0] WIDE_OFF_B     = 24'd43584;
    localparam logic [23:0] WIDE_OFF_C     = 24'd138463;
    localparam logic [23:0] WIDE_OFF_D     = 24'd246944;
    localparam logic [23:0] WIDE_OFF_E     = 24'd249952;
    localparam logic [6:0]  POS_PER_SECT   = 7'd94;

    // command queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_START,
        KIND_TICK,
        KIND_NOP
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_READ
    } t_phase;

    // classified command handed from front to back
    typedef struct packed {
        t_kind        kind;
        logic [23:0]  addr;
        logic [5:0]   nbytes;
        logic         invalid;
        logic         miso;
    } t_cmd;

    // queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/core/frgf_front.sv
// ----------------------------------------------------------------------------
// frgf_front
// accepts input words, classifies them and maps codes to rom addresses
// ----------------------------------------------------------------------------
module frgf_front #(
    parameter int ASCII_GLYPH_BYTES = frgf_pkg::ASCII_GLYPH_BYTES_DEF,
    parameter int WIDE_GLYPH_BYTES  = frgf_pkg::WIDE_GLYPH_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_code_first,
    input  logic [7:0]       i_code_second,
    input  logic             i_miso_bit,
    input  frgf_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output frgf_pkg::t_cmd   o_cmd
);

    logic                  r_valid;
    frgf_pkg::t_kind       r_kind;
    logic [11:0]           r_idx;
    logic                  r_ascii;
    logic [23:0]           r_off;
    logic [5:0]            r_nbytes;
    logic                  r_invalid;
    logic                  r_miso;

    frgf_pkg::t_kind       n_kind;
    logic [11:0]           n_idx;
    logic                  n_ascii;
    logic [23:0]           n_off;
    logic [5:0]            n_nbytes;
    logic                  n_invalid;

    logic [5:0]            row;
    logic [23:0]           wide_off;
    logic                  wide_ok;
    logic [6:0]            pos_m1;
    logic                  accept;

    assign o_ready = !r_valid || !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid && !i_q_stat.full;

    // section/position range decode
    always_comb begin
        row      = 6'd0;
        wide_off = frgf_pkg::WIDE_OFF_A;
        wide_ok  = 1'b1;
        pos_m1   = 7'(i_code_second - 8'd1);
        if (i_code_first inside {[8'd1:8'd15]}) begin
            row = 6'(i_code_first - 8'd1);
        end else if (i_code_first inside {[8'd16:8'd47]}) begin
            row      = 6'(i_code_first - 8'd16);
            wide_off = frgf_pkg::WIDE_OFF_B;
        end else if (i_code_first inside {[8'd48:8'd84]}) begin
            row      = 6'(i_code_first - 8'd48);
            wide_off = frgf_pkg::WIDE_OFF_C;
        end else if (i_code_first == 8'd85) begin
            wide_off = frgf_pkg::WIDE_OFF_D;
        end else if (i_code_first inside {[8'd88:8'd89]}) begin
            row      = 6'(i_code_first - 8'd88);
            wide_off = frgf_pkg::WIDE_OFF_E;
        end else begin
            wide_ok = 1'b0;
        end
        if (!(i_code_second inside {[8'd1:8'd94]})) begin
            wide_ok = 1'b0;
        end
    end

    // classify the input word
    always_comb begin
        n_kind    = frgf_pkg::KIND_NOP;
        n_idx     = 12'd0;
        n_ascii   = 1'b0;
        n_off     = 24'd0;
        n_nbytes  = 6'd0;
        n_invalid = 1'b0;
        case (i_opcode)
            frgf_pkg::OP_START_ASCII: begin
                n_kind   = frgf_pkg::KIND_START;
                n_ascii  = 1'b1;
                n_nbytes = 6'(ASCII_GLYPH_BYTES);
                if (i_code_first inside {[8'h20:8'h7F]}) begin
                    n_idx = 12'(i_code_first - 8'h20);
                    n_off = frgf_pkg::ASCII_BASE;
                end else begin
                    n_invalid = 1'b1;
                end
            end
            frgf_pkg::OP_START_WIDE: begin
                n_kind   = frgf_pkg::KIND_START;
                n_nbytes = 6'(WIDE_GLYPH_BYTES);
                if (wide_ok) begin
                    n_idx = 12'(row) * 12'(frgf_pkg::POS_PER_SECT) + 12'(pos_m1);
                    n_off = wide_off;
                end else begin
                    n_invalid = 1'b1;
                end
            end
            frgf_pkg::OP_TICK: begin
                n_kind = frgf_pkg::KIND_TICK;
            end
            default: begin
                n_kind = frgf_pkg::KIND_NOP;
            end
        endcase
    end

    // front register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= n_kind;
            r_idx     <= n_idx;
            r_ascii   <= n_ascii;
            r_off     <= n_off;
            r_nbytes  <= n_nbytes;
            r_invalid <= n_invalid;
            r_miso    <= i_miso_bit;
        end
    end

    // final address: glyph index times 16 (ascii) or 32 (wide) plus base
    always_comb begin
        o_cmd.kind    = r_kind;
        o_cmd.addr    = r_ascii ? (24'({r_idx, 4'b0}) + r_off) : (24'({r_idx, 5'b0}) + r_off);
        o_cmd.nbytes  = r_nbytes;
        o_cmd.invalid = r_invalid;
        o_cmd.miso    = r_miso;
    end

endmodule

>>> rtl/core/frgf_queue.sv
// ----------------------------------------------------------------------------
// frgf_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module frgf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  frgf_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output frgf_pkg::t_cmd    o_cmd,
    output frgf_pkg::t_q_stat o_stat
);

    frgf_pkg::t_cmd                r_mem [frgf_pkg::QUEUE_DEPTH];
    logic [frgf_pkg::QPTR_W-1:0]   r_wptr;
    logic [frgf_pkg::QPTR_W-1:0]   r_rptr;
    logic [frgf_pkg::QPTR_W:0]     r_count;

    assign o_stat.full  = (r_count == (frgf_pkg::QPTR_W+1)'(frgf_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + (frgf_pkg::QPTR_W)'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + (frgf_pkg::QPTR_W)'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (frgf_pkg::QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (frgf_pkg::QPTR_W+1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/frgf_back.sv
// ----------------------------------------------------------------------------
// frgf_back
// serial link sequencer and output register
// ----------------------------------------------------------------------------
module frgf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frgf_pkg::t_cmd    i_cmd,
    input  frgf_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_data,
    output logic              o_user,
    output logic              o_last
);

    frgf_pkg::t_phase r_phase, n_phase;
    logic [39:0]      r_hshift, n_hshift;
    logic [5:0]       r_hleft, n_hleft;
    logic [7:0]       r_rshift, n_rshift;
    logic [2:0]       r_rcount, n_rcount;
    logic [5:0]       r_bleft, n_bleft;
    logic             r_mosi, n_mosi;

    logic             r_o_valid;
    logic [15:0]      r_o_data;
    logic             r_o_user;
    logic             r_o_last;

    logic             busy;
    logic             busy_after;
    logic             res_valid;
    logic [7:0]       res_data;
    logic             res_last;
    logic             res_invalid;

    assign o_pop   = !i_q_stat.empty && (!r_o_valid || i_ready);
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_user  = r_o_user;
    assign o_last  = r_o_last;

    assign busy = (r_phase == frgf_pkg::PH_HEADER) || (r_phase == frgf_pkg::PH_READ);

    // next state for one command
    always_comb begin
        n_phase     = r_phase;
        n_hshift    = r_hshift;
        n_hleft     = r_hleft;
        n_rshift    = r_rshift;
        n_rcount    = r_rcount;
        n_bleft     = r_bleft;
        n_mosi      = r_mosi;
        res_valid   = 1'b0;
        res_data    = 8'd0;
        res_last    = 1'b0;
        res_invalid = 1'b0;
        case (i_cmd.kind)
            frgf_pkg::KIND_START: begin
                if (!busy) begin
                    n_hshift    = {frgf_pkg::CMD_FAST_READ, i_cmd.addr, frgf_pkg::DUMMY_BYTE};
                    n_hleft     = frgf_pkg::HEADER_BITS;
                    n_rshift    = 8'd0;
                    n_rcount    = 3'd0;
                    n_bleft     = i_cmd.nbytes;
                    n_phase     = frgf_pkg::PH_HEADER;
                    res_invalid = i_cmd.invalid;
                end
            end
            frgf_pkg::KIND_TICK: begin
                case (r_phase)
                    frgf_pkg::PH_HEADER: begin
                        n_mosi   = r_hshift[39];
                        n_hshift = {r_hshift[38:0], 1'b0};
                        if (r_hleft != 6'd0) begin
                            n_hleft = r_hleft - 6'd1;
                        end
                        if (n_hleft == 6'd0) begin
                            n_phase = (r_bleft != 6'd0) ? frgf_pkg::PH_READ
                                                        : frgf_pkg::PH_IDLE;
                        end
                    end
                    frgf_pkg::PH_READ: begin
                        n_rshift = {r_rshift[6:0], i_cmd.miso};
                        n_rcount = r_rcount + 3'd1;
                        if (n_rcount == 3'd0) begin
                            res_valid = 1'b1;
                            res_data  = n_rshift;
                            if (r_bleft != 6'd0) begin
                                n_bleft = r_bleft - 6'd1;
                            end
                            if (n_bleft == 6'd0) begin
                                res_last = 1'b1;
                                n_phase  = frgf_pkg::PH_IDLE;
                            end
                            n_rshift = 8'd0;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        busy_after = (n_phase == frgf_pkg::PH_HEADER) || (n_phase == frgf_pkg::PH_READ);
    end

    // link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= frgf_pkg::PH_IDLE;
            r_hshift <= '0;
            r_hleft  <= '0;
            r_rshift <= '0;
            r_rcount <= '0;
            r_bleft  <= '0;
            r_mosi   <= 1'b0;
        end else if (o_pop) begin
            r_phase  <= n_phase;
            r_hshift <= n_hshift;
            r_hleft  <= n_hleft;
            r_rshift <= n_rshift;
            r_rcount <= n_rcount;
            r_bleft  <= n_bleft;
            r_mosi   <= n_mosi;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_pop) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_data <= {4'd0, res_invalid, busy_after, res_data, n_mosi, !busy_after};
            r_o_user <= res_valid;
            r_o_last <= res_last;
        end
    end

endmodule

>>> rtl/core/font_rom_glyph_fetch.sv
// path: an accepted input word passes the front reg, the queue and the out reg before its result word
// throughput: one word per cycle while m_axis_tready holds; the sequencer handles one command per cycle
// the 4-entry command queue absorbs short output stalls, longer ones back up to the input
// reset: synchronous active-low i_rst_n; link goes idle, queue and output empty
// ----------------------------------------------------------------------------
// font_rom_glyph_fetch
// fetches one glyph from a serial font rom over a fast-read link
// ----------------------------------------------------------------------------
`include "font_rom_glyph_fetch_defines.svh"

module font_rom_glyph_fetch #(
    parameter int ASCII_GLYPH_BYTES = frgf_pkg::ASCII_GLYPH_BYTES_DEF,
    parameter int WIDE_GLYPH_BYTES  = frgf_pkg::WIDE_GLYPH_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // code_first, code_second, miso_bit, zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // chip_select_n, mosi_bit, data_byte, busy_res,
                                        // code_invalid, zero pad
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // last_byte
);

    frgf_pkg::t_cmd    front_cmd;
    frgf_pkg::t_cmd    queue_cmd;
    frgf_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;

    // front: accept and classify
    frgf_front #(
        .ASCII_GLYPH_BYTES (ASCII_GLYPH_BYTES),
        .WIDE_GLYPH_BYTES  (WIDE_GLYPH_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_opcode      (s_axis_tuser),
        .i_code_first  (s_axis_tdata[7:0]),
        .i_code_second (s_axis_tdata[15:8]),
        .i_miso_bit    (s_axis_tdata[16]),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // command queue
    frgf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    // back: link sequencer
    frgf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (queue_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

    // checks
    `FRGF_ASSERT(a_q_stat_sane, i_clk, i_rst_n,
        !(q_stat.full && q_stat.empty), "queue full and empty")
    `FRGF_ASSERT(a_cs_vs_busy, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[10]), "select disagrees with busy")
    `FRGF_ASSERT(a_last_is_byte, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser && !m_axis_tdata[10]),
        "last without byte or still busy")
    `FRGF_ASSERT(a_pop_nonempty, i_clk, i_rst_n, pop |-> !q_stat.empty, "pop from empty queue")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the glyph fetch block word by word against a behavioral predictor:
// a directed table walks idle words, ignored starts and code edges, each fetch
// is clocked out with tick words, then random well-formed fetches with noise
// follow, under random idling on both stream sides
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         N_ITEMS   = 1550;

    // one result word, unpacked into its fields
    typedef struct packed {
        logic       cs_n;
        logic       mosi;
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       busy;
        logic       inv;
    } t_glyph_word;

    // one row of the directed table
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic        drain;
        logic        typed;
        t_glyph_word want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // code_first, code_second, miso_bit, zero pad
    logic [1:0]  s_axis_tuser = '0;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // chip_select_n, mosi_bit, data_byte, busy_res,
                                      // code_invalid, zero pad
    logic        m_axis_tuser;        // byte_valid
    logic        m_axis_tlast;        // last_byte

    t_glyph_word glyph_words_due[$];
    t_stim_row   dir_rows[$];
    int          fails = 0;
    int          sent = 0;
    logic        calm = 1'b0;

    // predicted link state
    frgf_pkg::t_phase ph = frgf_pkg::PH_IDLE;
    logic [39:0] hdr = '0;
    logic [5:0]  hdr_left = '0;
    logic [7:0]  rx = '0;
    logic [2:0]  rx_cnt = '0;
    logic [5:0]  bytes_left = '0;
    logic        mosi_q = 1'b0;

    font_rom_glyph_fetch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // result word with no byte, as after reset or on a start
    function automatic t_glyph_word quiet_word(input logic cs_n, input logic mosi,
                                               input logic inv);
        t_glyph_word w;
        w      = '0;
        w.cs_n = cs_n;
        w.mosi = mosi;
        w.busy = ~cs_n;
        w.inv  = inv;
        return w;
    endfunction

    // section/position to rom address, ok low when outside every range
    function automatic logic [23:0] wide_addr(input logic [7:0] c1, input logic [7:0] c2,
                                              output logic ok);
        int s;
        int p;
        int a;
        s  = c1;
        p  = c2;
        a  = 0;
        ok = 1'b1;
        if (p < 1 || p > 94) ok = 1'b0;
        else if (s >= 1 && s <= 15)
            a = ((s - 1) * 94 + p - 1) * 32 + int'(frgf_pkg::WIDE_OFF_A);
        else if (s >= 16 && s <= 47)
            a = ((s - 16) * 94 + p - 1) * 32 + int'(frgf_pkg::WIDE_OFF_B);
        else if (s >= 48 && s <= 84)
            a = ((s - 48) * 94 + p - 1) * 32 + int'(frgf_pkg::WIDE_OFF_C);
        else if (s == 85)
            a = (p - 1) * 32 + int'(frgf_pkg::WIDE_OFF_D);
        else if (s >= 88 && s <= 89)
            a = ((s - 88) * 94 + p - 1) * 32 + int'(frgf_pkg::WIDE_OFF_E);
        else ok = 1'b0;
        return ok ? 24'(a) : 24'd0;
    endfunction

    // arm the command header for a new fetch
    task automatic load_header(input logic [23:0] addr, input int nbytes);
        hdr        = {frgf_pkg::CMD_FAST_READ, addr, frgf_pkg::DUMMY_BYTE};
        hdr_left   = frgf_pkg::HEADER_BITS;
        rx         = '0;
        rx_cnt     = '0;
        bytes_left = 6'(nbytes);
        ph         = frgf_pkg::PH_HEADER;
    endtask

    // advance the predicted link by one accepted word
    task automatic fetch_step(input logic [1:0] op, input logic [7:0] c1,
                              input logic [7:0] c2, input logic miso,
                              output t_glyph_word w);
        logic        busy_now;
        logic        ok;
        logic [23:0] addr;
        w        = '0;
        busy_now = (ph == frgf_pkg::PH_HEADER || ph == frgf_pkg::PH_READ);
        if (op == frgf_pkg::OP_START_ASCII && !busy_now) begin
            ok    = (c1 >= 8'h20 && c1 <= 8'h7F);
            addr  = ok ? 24'((int'(c1) - 32) * 16 + int'(frgf_pkg::ASCII_BASE)) : 24'd0;
            w.inv = ~ok;
            load_header(addr, frgf_pkg::ASCII_GLYPH_BYTES_DEF);
        end else if (op == frgf_pkg::OP_START_WIDE && !busy_now) begin
            addr  = wide_addr(c1, c2, ok);
            w.inv = ~ok;
            load_header(addr, frgf_pkg::WIDE_GLYPH_BYTES_DEF);
        end else if (op == frgf_pkg::OP_TICK) begin
            if (ph == frgf_pkg::PH_HEADER) begin
                mosi_q = hdr[39];
                hdr    = hdr << 1;
                if (hdr_left != 0) hdr_left--;
                if (hdr_left == 0)
                    ph = (bytes_left != 0) ? frgf_pkg::PH_READ : frgf_pkg::PH_IDLE;
            end else if (ph == frgf_pkg::PH_READ) begin
                rx     = {rx[6:0], miso};
                rx_cnt = rx_cnt + 3'd1;
                if (rx_cnt == 0) begin
                    w.valid = 1'b1;
                    w.data  = rx;
                    if (bytes_left != 0) bytes_left--;
                    if (bytes_left == 0) begin
                        w.last = 1'b1;
                        ph     = frgf_pkg::PH_IDLE;
                    end
                    rx = '0;
                end
            end
        end
        w.busy = (ph == frgf_pkg::PH_HEADER || ph == frgf_pkg::PH_READ);
        w.cs_n = ~w.busy;
        w.mosi = mosi_q;
    endtask

    // offer one word, predict it on acceptance
    task automatic send_word(input logic [1:0] op, input logic [7:0] c1, input logic [7:0] c2,
                             input logic miso, input logic typed, input t_glyph_word want);
        t_glyph_word w;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'b0, miso, c2, c1};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fetch_step(op, c1, c2, miso, w);
        glyph_words_due.push_back(typed ? want : w);
        sent++;
    endtask

    // hold the input until every predicted word has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (glyph_words_due.size() != 0) @(posedge i_clk);
    endtask

    // clock a running fetch to its end with random rom data
    task automatic drain_glyph();
        while (ph == frgf_pkg::PH_HEADER || ph == frgf_pkg::PH_READ)
            send_word(frgf_pkg::OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // output side stall bursts
    int sink_hold = 0;
    always @(posedge i_clk) begin
        if (sink_hold == 0 && !calm && $urandom_range(0, 9) == 0)
            sink_hold = $urandom_range(1, 13);
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        t_glyph_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (glyph_words_due.size() == 0) begin
                $error("result word with no prediction waiting");
                fails++;
            end else begin
                want = glyph_words_due.pop_front();
                check_field("chip_select_n", want.cs_n, m_axis_tdata[0]);
                check_field("mosi_bit", want.mosi, m_axis_tdata[1]);
                check_field("byte_valid", want.valid, m_axis_tuser);
                check_field("data_byte", want.data, m_axis_tdata[9:2]);
                check_field("last_byte", want.last, m_axis_tlast);
                check_field("busy_res", want.busy, m_axis_tdata[10]);
                check_field("code_invalid", want.inv, m_axis_tdata[11]);
            end
        end
    end

    // stimulus
    initial begin
        int r;
        int s;
        logic [1:0] op;
        logic [7:0] c1;
        logic [7:0] c2;

        // directed table: op, code_first, code_second, drain, typed, expected
        dir_rows.push_back('{frgf_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, 1'b1,
                             quiet_word(1, 0, 0)});
        dir_rows.push_back('{OP_UNUSED, 8'hFF, 8'hFF, 1'b0, 1'b1, quiet_word(1, 0, 0)});
        dir_rows.push_back('{frgf_pkg::OP_START_ASCII, 8'h1F, 8'h00, 1'b0, 1'b1,
                             quiet_word(0, 0, 1)});
        dir_rows.push_back('{frgf_pkg::OP_START_WIDE, 8'd1, 8'd1, 1'b1, 1'b1,
                             quiet_word(0, 0, 0)});
        dir_rows.push_back('{frgf_pkg::OP_START_ASCII, 8'h7F, 8'h00, 1'b1, 1'b0, '0});
        dir_rows.push_back('{frgf_pkg::OP_START_WIDE, 8'd86, 8'd1, 1'b1, 1'b1,
                             quiet_word(0, 1, 1)});
        dir_rows.push_back('{frgf_pkg::OP_START_WIDE, 8'd85, 8'd94, 1'b1, 1'b0, '0});

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].op, dir_rows[i].c1, dir_rows[i].c2, 1'($urandom),
                      dir_rows[i].typed, dir_rows[i].want);
            if (dir_rows[i].drain) drain_glyph();
        end
        settle();

        // random fetches, mostly well formed, with ignored words mixed in
        while (sent < N_ITEMS) begin
            calm = (sent > N_ITEMS - 200);
            if (!calm && $urandom_range(0, 299) == 0) settle();
            r  = $urandom_range(0, 99);
            c1 = 8'($urandom);
            c2 = 8'($urandom);
            if (ph == frgf_pkg::PH_HEADER || ph == frgf_pkg::PH_READ) begin
                if (r < 3) begin
                    send_word(2'($urandom_range(0, 1)), c1, c2, 1'($urandom), 1'b0, '0);
                end else if (r < 6) begin
                    send_word(OP_UNUSED, c1, c2, 1'($urandom), 1'b0, '0);
                end else begin
                    send_word(frgf_pkg::OP_TICK, c1, c2, 1'($urandom), 1'b0, '0);
                end
            end else if (r < 8) begin
                op = $urandom_range(0, 1) ? frgf_pkg::OP_TICK : OP_UNUSED;
                send_word(op, c1, c2, 1'($urandom), 1'b0, '0);
            end else begin
                op = 2'($urandom_range(0, 1));
                if (r < 80) begin
                    if (op == frgf_pkg::OP_START_ASCII) begin
                        c1 = 8'($urandom_range(8'h20, 8'h7F));
                    end else begin
                        do s = $urandom_range(1, 89); while (s == 86 || s == 87);
                        c1 = 8'(s);
                        c2 = 8'($urandom_range(1, 94));
                    end
                end
                send_word(op, c1, c2, 1'($urandom), 1'b0, '0);
            end
        end

        // wait out the pipeline
        settle();
        repeat (16) @(posedge i_clk);
        if (fails == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
